>>> rtl/c8ie_pkg.sv
`timescale 1ns / 1ps
package c8ie_pkg;

  // One input item
  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [15:0] instruction;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } in_t;

  // One result item
  typedef struct packed {
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic [7:0]  flag_value;
    logic [63:0] row_bits;
    logic        status;
  } out_t;

  // Action codes
  localparam logic [1:0] ACT_MEM_WRITE = 2'd0;
  localparam logic [1:0] ACT_EXECUTE   = 2'd1;
  localparam logic [1:0] ACT_ROW_READ  = 2'd2;
  localparam logic [1:0] ACT_UNUSED    = 2'd3;

  // Opcode groups (top nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEK  = 4'h3;
  localparam logic [3:0] OP_SNEK = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDK  = 4'h6;
  localparam logic [3:0] OP_ADDK = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;

  localparam logic [15:0] INSTR_CLS = 16'h00E0;
  localparam logic [15:0] INSTR_RET = 16'h00EE;

  // 8xy sub-operations
  localparam logic [3:0] SUB_LD   = 4'h0;
  localparam logic [3:0] SUB_OR   = 4'h1;
  localparam logic [3:0] SUB_AND  = 4'h2;
  localparam logic [3:0] SUB_XOR  = 4'h3;
  localparam logic [3:0] SUB_ADD  = 4'h4;
  localparam logic [3:0] SUB_SUB  = 4'h5;
  localparam logic [3:0] SUB_SHR  = 4'h6;
  localparam logic [3:0] SUB_SUBN = 4'h7;
  localparam logic [3:0] SUB_SHL  = 4'hE;

  localparam logic [3:0] REG_VF = 4'hF;
  localparam int         ROW_IDX_W = 7;

  typedef enum logic [2:0] {
    ALU_PASSB, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RX, ST_RY, ST_EXE, ST_WB, ST_DRD, ST_DXOR, ST_DVF, ST_VRD, ST_OUT
  } state_t;

  // Video port controls
  typedef struct packed {
    logic                 clear;
    logic                 we;
    logic [ROW_IDX_W-1:0] waddr;
    logic [63:0]          wdata;
    logic [ROW_IDX_W-1:0] raddr;
  } vid_ctl_t;

  // Remainder by a constant, by restoring subtraction (quotient below 32)
  function automatic logic [12:0] mod_const(input logic [12:0] v, input logic [12:0] m);
    logic [17:0] acc;
    logic [17:0] sub;
    acc = {5'd0, v};
    for (int k = 4; k >= 0; k--) begin
      sub = {5'd0, m} << k;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    return acc[12:0];
  endfunction

endpackage

>>> rtl/chip8_instruction_execute.sv
`timescale 1ns / 1ps
// Channel  Ports                          Payload
// input    in_valid / in_ready / in_data  c8ie_pkg::in_t
// result   out_valid / out_ready / out_data c8ie_pkg::out_t
//
// Memory write, row read and unused action skip to the row and output states.
// Instructions read Vx and Vy and execute; implemented 8xy ops write back
// later. DRW makes one video read-modify-write pass per drawn row (up to 15).
// Sync active-low reset clears screen, registers, I, SP; PC = PROGRAM_START.
// in_ready is high only when idle; a result waits in the output register
// while out_ready is low, and the next item may be taken meanwhile.
module chip8_instruction_execute #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32,
  parameter int PROGRAM_START = 512,
  parameter int STACK_DEPTH   = 16,
  parameter int MEMORY_BYTES  = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  c8ie_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output c8ie_pkg::out_t  out_data
);
  import c8ie_pkg::*;

  localparam int MAW = $clog2(MEMORY_BYTES);
  localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);
  localparam logic [63:0] COL_MASK = ~({64{1'b1}} >> SCREEN_WIDTH);
  localparam logic [12:0] MEM_M = 13'(MEMORY_BYTES);
  localparam logic [12:0] WID_M = 13'(SCREEN_WIDTH);
  localparam logic [12:0] HGT_M = 13'(SCREEN_HEIGHT);
  localparam logic [ROW_IDX_W-1:0] HGT_R = ROW_IDX_W'(SCREEN_HEIGHT);

  state_t st_r, st_nxt;
  in_t    item_r;
  logic   in_fire;

  logic [11:0] pc_r, pc_nxt, idx_r, idx_nxt;
  logic [SPW-1:0] sp_r, sp_nxt, spm1;
  logic [7:0] vx_r, vx_nxt, res_r, res_nxt;
  logic [7:0] vf_r;
  logic status_r, status_nxt;
  logic [5:0] x0_r, x0_nxt;
  logic [ROW_IDX_W-1:0] y0_r, y0_nxt;
  logic [3:0] drow_r, drow_nxt;
  logic coll_r, coll_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  // Decoded fields
  logic [3:0]  op_hi, rx, ry, rn;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2;
  assign op_hi = item_r.instruction[15:12];
  assign rx    = item_r.instruction[11:8];
  assign ry    = item_r.instruction[7:4];
  assign rn    = item_r.instruction[3:0];
  assign kk    = item_r.instruction[7:0];
  assign nnn   = item_r.instruction[11:0];
  assign pc2   = pc_r + 12'd2;
  assign spm1  = (sp_r == '0) ? SP_LAST : sp_r - 1'b1;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Register file with valid bits, single write port, registered read
  logic [7:0]  gregs [16];
  logic [15:0] gv_r;
  logic        rf_we;
  logic [3:0]  rf_waddr, rf_raddr;
  logic [7:0]  rf_wdata, rf_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r <= '0;
      vf_r <= 8'd0;
    end else if (rf_we) begin
      gv_r[rf_waddr] <= 1'b1;
      if (rf_waddr == REG_VF) begin
        vf_r <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      gregs[rf_waddr] <= rf_wdata;
    end
    rf_q <= gv_r[rf_raddr] ? gregs[rf_raddr] : 8'd0;
  end

  // Return stack, registered read at SP-1
  logic [11:0] stk [STACK_DEPTH];
  logic        stk_we;
  logic [11:0] stk_q;

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[sp_r] <= pc2;
    end
    stk_q <= stk[spm1];
  end

  // Sprite memory
  logic [12:0] mem_wa_full, mem_ra_full;
  logic [7:0]  mem_q;
  assign mem_wa_full = mod_const({1'b0, in_data.mem_address}, MEM_M);
  assign mem_ra_full = mod_const({1'b0, idx_r} + {9'd0, drow_r}, MEM_M);

  c8ie_mem #(.DEPTH(MEMORY_BYTES)) u_mem (
    .clk   (clk),
    .we    (in_fire && (in_data.action == ACT_MEM_WRITE)),
    .waddr (mem_wa_full[MAW-1:0]),
    .wdata (in_data.mem_data),
    .raddr (mem_ra_full[MAW-1:0]),
    .rdata (mem_q)
  );

  // Video rows
  vid_ctl_t    vctl;
  logic [63:0] vid_q;
  c8ie_vid #(.HEIGHT(SCREEN_HEIGHT)) u_vid (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (vctl),
    .rdata (vid_q)
  );

  // Shared ALU
  alu_op_t    alu_op;
  logic [7:0] alu_a, alu_b, alu_res;
  logic       alu_flag, alu_eq;
  c8ie_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag),
    .eq   (alu_eq)
  );

  // Draw datapath
  logic [63:0] spr_mask;
  logic [ROW_IDX_W-1:0] dy;
  logic [12:0] x0_full, y0_full;
  assign spr_mask = ({mem_q, 56'd0} >> x0_r) & COL_MASK;
  assign dy       = y0_r + ROW_IDX_W'(drow_r);
  assign x0_full  = mod_const({5'd0, vx_r}, WID_M);
  assign y0_full  = mod_const({5'd0, rf_q}, HGT_M);

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= 12'(PROGRAM_START);
      idx_r       <= 12'd0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    vx_r     <= vx_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    drow_r   <= drow_nxt;
    coll_r   <= coll_nxt;
    out_r    <= out_nxt;
  end

  // Sequencer
  always_comb begin
    st_nxt        = st_r;
    pc_nxt        = pc_r;
    idx_nxt       = idx_r;
    sp_nxt        = sp_r;
    vx_nxt        = vx_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    drow_nxt      = drow_r;
    coll_nxt      = coll_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    rf_we         = 1'b0;
    rf_waddr      = rx;
    rf_wdata      = alu_res;
    rf_raddr      = rx;
    stk_we        = 1'b0;
    alu_op        = ALU_PASSB;
    alu_a         = vx_r;
    alu_b         = rf_q;
    vctl          = '0;
    vctl.raddr    = dy;
    vctl.waddr    = dy;
    vctl.wdata    = vid_q ^ spr_mask;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          status_nxt = (in_data.action == ACT_UNUSED);
          st_nxt     = (in_data.action == ACT_EXECUTE) ? ST_RX : ST_VRD;
        end
      end

      ST_RX: begin
        rf_raddr = (op_hi == OP_JPV0) ? 4'd0 : rx;
        st_nxt   = ST_RY;
      end

      ST_RY: begin
        vx_nxt   = rf_q;
        rf_raddr = ry;
        st_nxt   = ST_EXE;
      end

      ST_EXE: begin
        pc_nxt = pc2;
        st_nxt = ST_VRD;
        unique case (op_hi)
          OP_SYS: begin
            if (item_r.instruction == INSTR_CLS) begin
              vctl.clear = 1'b1;
            end else if (item_r.instruction == INSTR_RET) begin
              sp_nxt = spm1;
              pc_nxt = stk_q;
            end else begin
              status_nxt = 1'b1;
            end
          end
          OP_JP: pc_nxt = nnn;
          OP_CALL: begin
            stk_we = 1'b1;
            sp_nxt = (sp_r == SP_LAST) ? '0 : sp_r + 1'b1;
            pc_nxt = nnn;
          end
          OP_SEK, OP_SNEK: begin
            alu_b = kk;
            if (alu_eq == (op_hi == OP_SEK)) begin
              pc_nxt = pc2 + 12'd2;
            end
          end
          OP_SER, OP_SNER: begin
            if (rn != 4'd0) begin
              status_nxt = 1'b1;
            end else if (alu_eq == (op_hi == OP_SER)) begin
              pc_nxt = pc2 + 12'd2;
            end
          end
          OP_LDK: begin
            rf_we    = 1'b1;
            rf_wdata = kk;
          end
          OP_ADDK: begin
            alu_op = ALU_ADD;
            alu_b  = kk;
            rf_we  = 1'b1;
          end
          OP_ALU: begin
            case (rn)
              SUB_LD:   alu_op = ALU_PASSB;
              SUB_OR:   alu_op = ALU_OR;
              SUB_AND:  alu_op = ALU_AND;
              SUB_XOR:  alu_op = ALU_XOR;
              SUB_ADD:  alu_op = ALU_ADD;
              SUB_SUB:  alu_op = ALU_SUB;
              SUB_SHR:  alu_op = ALU_SHR;
              SUB_SUBN: begin
                alu_op = ALU_SUB;
                alu_a  = rf_q;
                alu_b  = vx_r;
              end
              SUB_SHL:  alu_op = ALU_SHL;
              default:  alu_op = ALU_PASSB;
            endcase
            res_nxt = alu_res;
            case (rn) inside
              SUB_LD, SUB_OR, SUB_AND, SUB_XOR: st_nxt = ST_WB;
              SUB_ADD, SUB_SUB, SUB_SHR, SUB_SUBN, SUB_SHL: begin
                // flag first, result afterwards so Vx wins when x is F
                rf_we    = 1'b1;
                rf_waddr = REG_VF;
                rf_wdata = {7'd0, alu_flag};
                st_nxt   = ST_WB;
              end
              default: status_nxt = 1'b1;
            endcase
          end
          OP_LDI:  idx_nxt = nnn;
          OP_JPV0: pc_nxt = nnn + {4'd0, vx_r};
          OP_RND: begin
            alu_op = ALU_AND;
            alu_a  = item_r.random_byte;
            alu_b  = kk;
            rf_we  = 1'b1;
          end
          OP_DRW: begin
            x0_nxt   = x0_full[5:0];
            y0_nxt   = y0_full[ROW_IDX_W-1:0];
            drow_nxt = 4'd0;
            coll_nxt = 1'b0;
            st_nxt   = (rn == 4'd0) ? ST_DVF : ST_DRD;
          end
          default: status_nxt = 1'b1;
        endcase
      end

      ST_WB: begin
        rf_we    = 1'b1;
        rf_wdata = res_r;
        st_nxt   = ST_VRD;
      end

      // sprite byte and screen row reads are issued here
      ST_DRD: begin
        st_nxt = ST_DXOR;
      end

      ST_DXOR: begin
        vctl.we  = 1'b1;
        coll_nxt = coll_r | (|(vid_q & spr_mask));
        drow_nxt = drow_r + 4'd1;
        if ((drow_r + 4'd1 == rn) || (dy + 1'b1 >= HGT_R)) begin
          st_nxt = ST_DVF;
        end else begin
          st_nxt = ST_DRD;
        end
      end

      ST_DVF: begin
        rf_we    = 1'b1;
        rf_waddr = REG_VF;
        rf_wdata = {7'd0, coll_r};
        st_nxt   = ST_VRD;
      end

      ST_VRD: begin
        vctl.raddr = {2'd0, item_r.row_select};
        st_nxt     = ST_OUT;
      end

      ST_OUT: begin
        // keep the selected row on the read port while the result waits
        vctl.raddr = {2'd0, item_r.row_select};
        if (!out_valid_r || out_ready) begin
          out_nxt.program_counter = pc_r;
          out_nxt.index_value     = idx_r;
          out_nxt.flag_value      = vf_r;
          out_nxt.row_bits        = ({2'd0, item_r.row_select} < HGT_R) ? vid_q : 64'd0;
          out_nxt.status          = status_r;
          out_valid_nxt           = 1'b1;
          st_nxt                  = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  // Checks
  a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && !out_valid_r) |=> (out_valid_r && st_r == ST_IDLE))
    else $error("result not loaded from output state");

  a_vf_shadow: assert property (@(posedge clk) disable iff (!rst_n)
    (rf_we && rf_waddr == REG_VF) |=> (vf_r == $past(rf_wdata)))
    else $error("VF shadow out of step with register file");

  a_draw_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DXOR) |-> (drow_r < rn && dy < HGT_R))
    else $error("sprite row past height or screen");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, sp_r} <= {1'b0, SP_LAST}))
    else $error("stack pointer out of range");
endmodule

>>> rtl/c8ie_alu.sv
`timescale 1ns / 1ps
module c8ie_alu (
  input  c8ie_pkg::alu_op_t op,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  output logic [7:0]        res,
  output logic              flag,
  output logic              eq
);
  import c8ie_pkg::*;

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};
  assign eq  = (a == b);

  // Shared 8-bit unit for the register ops, adds and skip compares
  always_comb begin
    res  = b;
    flag = 1'b0;
    unique case (op)
      ALU_PASSB: res = b;
      ALU_OR:    res = a | b;
      ALU_AND:   res = a & b;
      ALU_XOR:   res = a ^ b;
      ALU_ADD: begin
        res  = sum[7:0];
        flag = sum[8];
      end
      ALU_SUB: begin
        res  = a - b;
        flag = (a > b);
      end
      ALU_SHR: begin
        res  = {1'b0, a[7:1]};
        flag = a[0];
      end
      ALU_SHL: begin
        res  = {a[6:0], 1'b0};
        flag = a[7];
      end
      default: res = b;
    endcase
  end
endmodule

>>> rtl/c8ie_mem.sv
`timescale 1ns / 1ps
module c8ie_mem #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/c8ie_vid.sv
`timescale 1ns / 1ps
module c8ie_vid #(
  parameter int HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  c8ie_pkg::vid_ctl_t ctl,
  output logic [63:0]        rdata
);
  import c8ie_pkg::*;

  localparam int RW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

  logic [63:0]       rows [HEIGHT];
  logic [HEIGHT-1:0] vld_r;
  logic [RW-1:0]     wa;
  logic [RW-1:0]     ra;

  assign wa = ctl.waddr[RW-1:0];
  assign ra = ctl.raddr[RW-1:0];

  // Row valid bits: reset and CLS blank the screen at once
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r <= '0;
    end else if (ctl.we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // Row storage, registered read; a row never written reads as blank
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      rows[wa] <= ctl.wdata;
    end
    rdata <= vld_r[ra] ? rows[ra] : 64'd0;
  end
endmodule

>>> tb/chip8_instruction_execute_tb.sv
`timescale 1ns / 1ps
module chip8_instruction_execute_tb;
  import c8ie_pkg::*;

  localparam int SCR_W = 64;
  localparam int SCR_H = 32;
  localparam int MEM_N = 4096;
  localparam int STK_N = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  chip8_instruction_execute uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow machine state
  logic [7:0]  mdl_mem [MEM_N];
  logic [63:0] mdl_video [SCR_H];
  logic [7:0]  mdl_v [16];
  logic [11:0] mdl_pc;
  logic [11:0] mdl_i;
  logic [11:0] mdl_stack [STK_N];
  logic [3:0]  mdl_sp;
  int          stack_fill;

  out_t exp_results[$];
  int   errors;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout
  initial begin
    #50ms;
    $display("chip8_instruction_execute verification failed");
    $finish;
  end

  // Predict one instruction; returns status
  function automatic logic run_opcode(logic [15:0] op, logic [7:0] rnd);
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [7:0]  res;
    logic [8:0]  sum;
    logic [7:0]  bits;
    int          x0;
    int          y0;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    vx = mdl_v[x];
    vy = mdl_v[y];
    mdl_pc = mdl_pc + 12'd2;
    case (op[15:12])
      OP_SYS: begin
        if (op == INSTR_CLS) begin
          for (int r = 0; r < SCR_H; r++) mdl_video[r] = '0;
          return 1'b0;
        end
        if (op == INSTR_RET) begin
          mdl_sp = mdl_sp - 4'd1;
          mdl_pc = mdl_stack[mdl_sp];
          stack_fill--;
          return 1'b0;
        end
        return 1'b1;
      end
      OP_JP: mdl_pc = op[11:0];
      OP_CALL: begin
        mdl_stack[mdl_sp] = mdl_pc;
        mdl_sp = mdl_sp + 4'd1;
        if (stack_fill < STK_N) stack_fill++;
        mdl_pc = op[11:0];
      end
      OP_SEK: if (vx == kk) mdl_pc = mdl_pc + 12'd2;
      OP_SNEK: if (vx != kk) mdl_pc = mdl_pc + 12'd2;
      OP_SER: begin
        if (n != 0) return 1'b1;
        if (vx == vy) mdl_pc = mdl_pc + 12'd2;
      end
      OP_LDK: mdl_v[x] = kk;
      OP_ADDK: mdl_v[x] = vx + kk;
      OP_ALU: begin
        case (n)
          SUB_LD:  res = vy;
          SUB_OR:  res = vx | vy;
          SUB_AND: res = vx & vy;
          SUB_XOR: res = vx ^ vy;
          SUB_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            mdl_v[REG_VF] = {7'd0, sum[8]};
            res = sum[7:0];
          end
          SUB_SUB: begin
            mdl_v[REG_VF] = {7'd0, vx > vy};
            res = vx - vy;
          end
          SUB_SHR: begin
            mdl_v[REG_VF] = {7'd0, vx[0]};
            res = vx >> 1;
          end
          SUB_SUBN: begin
            mdl_v[REG_VF] = {7'd0, vy > vx};
            res = vy - vx;
          end
          SUB_SHL: begin
            mdl_v[REG_VF] = {7'd0, vx[7]};
            res = vx << 1;
          end
          default: return 1'b1;
        endcase
        mdl_v[x] = res;
      end
      OP_SNER: begin
        if (n != 0) return 1'b1;
        if (vx != vy) mdl_pc = mdl_pc + 12'd2;
      end
      OP_LDI: mdl_i = op[11:0];
      OP_JPV0: mdl_pc = op[11:0] + {4'd0, mdl_v[0]};
      OP_RND: mdl_v[x] = rnd & kk;
      OP_DRW: begin
        x0 = vx % SCR_W;
        y0 = vy % SCR_H;
        mdl_v[REG_VF] = 8'd0;
        for (int r = 0; r < n; r++) begin
          if (y0 + r >= SCR_H) break;
          bits = mdl_mem[(mdl_i + r) % MEM_N];
          for (int c = 0; c < 8; c++) begin
            if (x0 + c >= SCR_W) break;
            if (bits[7 - c]) begin
              if (mdl_video[y0 + r][63 - x0 - c]) mdl_v[REG_VF] = 8'd1;
              mdl_video[y0 + r][63 - x0 - c] ^= 1'b1;
            end
          end
        end
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  // Predict the result of one transfer
  function automatic out_t predict_state(in_t it);
    out_t o;
    logic st;
    st = 1'b0;
    case (it.action)
      ACT_MEM_WRITE: mdl_mem[it.mem_address] = it.mem_data;
      ACT_EXECUTE: st = run_opcode(it.instruction, it.random_byte);
      ACT_UNUSED: st = 1'b1;
      default: ;
    endcase
    o.program_counter = mdl_pc;
    o.index_value = mdl_i;
    o.flag_value = mdl_v[REG_VF];
    o.row_bits = (it.row_select < SCR_H) ? mdl_video[it.row_select] : 64'd0;
    o.status = st;
    return o;
  endfunction

  // Send one item, honoring sender idling; valid stays up until the next item
  task automatic send_item(in_t it);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_results.push_back(predict_state(it));
  endtask

  // Randomize the unused fields of an item
  function automatic in_t rand_item(logic [1:0] act);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.action = act;
    return it;
  endfunction

  task automatic send_op(logic [15:0] op);
    in_t it;
    it = rand_item(ACT_EXECUTE);
    it.instruction = op;
    send_item(it);
  endtask

  task automatic send_write(logic [11:0] a, logic [7:0] d);
    in_t it;
    it = rand_item(ACT_MEM_WRITE);
    it.mem_address = a;
    it.mem_data = d;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          errors++;
        end else begin
          out_t e;
          e = exp_results.pop_front();
          if (e.program_counter !== out_data.program_counter) begin
            $display("%0t: pc exp %h got %h", $realtime, e.program_counter,
                     out_data.program_counter);
            errors++;
          end
          if (e.index_value !== out_data.index_value) begin
            $display("%0t: I exp %h got %h", $realtime, e.index_value,
                     out_data.index_value);
            errors++;
          end
          if (e.flag_value !== out_data.flag_value) begin
            $display("%0t: VF exp %h got %h", $realtime, e.flag_value,
                     out_data.flag_value);
            errors++;
          end
          if (e.row_bits !== out_data.row_bits) begin
            $display("%0t: row exp %h got %h", $realtime, e.row_bits,
                     out_data.row_bits);
            errors++;
          end
          if (e.status !== out_data.status) begin
            $display("%0t: status exp %b got %b", $realtime, e.status,
                     out_data.status);
            errors++;
          end
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Load a sprite area so draws read written memory only
  task automatic test_memory_fill();
    for (int a = 0; a < 24; a++) send_write(12'(a + 'h300), 8'($urandom));
    send_write(12'hFFF, 8'hFF);
    send_write(12'h000, 8'h81);
  endtask

  task automatic test_directed();
    in_t it;
    send_op(16'h6A3C);           // LD VA
    send_op(16'h7AFF);           // ADD wrap
    send_op(16'h6BFF);
    send_op(16'h8AB4);           // carry
    send_op(16'h8AB5);           // borrow
    send_op(16'h8AB7);           // SUBN
    send_op(16'h8A06);           // SHR
    send_op(16'h8A0E);           // SHL
    send_op(16'h6F81);
    send_op(16'h8FF6);           // VF as destination
    send_op(16'h8AB1);
    send_op(16'h8AB2);
    send_op(16'h8AB3);
    send_op(16'h8AB0);
    send_op(16'h8AB8);           // unimplemented ALU
    send_op(16'h5AB1);           // unimplemented skip
    send_op(16'h0123);           // SYS
    send_op(16'hE09E);
    send_op(16'h3A00);
    send_op(16'h4A00);
    send_op(16'h5AA0);
    send_op(16'h9AB0);
    send_op(16'hA300);
    send_op(16'h603E); send_op(16'h611E);
    send_op(16'hD01F);           // clipped at right and bottom
    send_op(16'hD01F);           // collision
    send_op(16'hD010);           // zero height
    send_op(16'hAFFF); send_op(16'hD012); // address wrap
    send_op(16'hA300);           // back to the sprite area
    send_op(16'h00E0);
    send_op(16'h2FFE); send_op(16'h00EE);
    send_op(16'h1FFE); send_op(16'h60FF); send_op(16'hBFFF); // PC wrap
    send_op(16'hC5F0);
    it = rand_item(ACT_UNUSED); send_item(it);
    it = rand_item(ACT_ROW_READ); it.row_select = 5'd31; send_item(it);
    it = rand_item(ACT_ROW_READ); it.row_select = 5'd0; send_item(it);
  endtask

  // Random instruction stream; draws use written memory, RET only with a valid entry
  task automatic test_random(int count);
    in_t it;
    logic [15:0] op;
    for (int k = 0; k < count; k++) begin
      int sel;
      sel = $urandom_range(99, 0);
      if (sel < 8) begin
        send_write(12'($urandom), 8'($urandom));
      end else if (sel < 16) begin
        it = rand_item(ACT_ROW_READ);
        send_item(it);
      end else if (sel < 18) begin
        send_item(rand_item(ACT_UNUSED));
      end else if (sel < 30) begin
        send_op({OP_DRW, 8'($urandom), 4'($urandom)});
      end else if (sel < 33) begin
        send_op({OP_LDI, 12'h300 + 12'($urandom_range(8, 0))});
      end else begin
        op = 16'($urandom);
        if (op == INSTR_RET && stack_fill == 0) op = INSTR_CLS;
        if (op[15:12] == OP_DRW || op[15:12] == OP_LDI) op[15:12] = OP_ALU;
        send_op(op);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles <= 300;
    for (int k = 0; k < 20; k++) send_op({OP_ALU, 12'($urandom)} & 16'hFFF7);
    drain_results();
    repeat (60) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stack_fill = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    for (int a = 0; a < MEM_N; a++) mdl_mem[a] = 8'd0;
    for (int r = 0; r < SCR_H; r++) mdl_video[r] = '0;
    for (int r = 0; r < 16; r++) mdl_v[r] = '0;
    for (int r = 0; r < STK_N; r++) mdl_stack[r] = '0;
    mdl_pc = 12'h200;
    mdl_i = '0;
    mdl_sp = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_memory_fill();
    test_directed();
    send_idle_pct = 27; recv_idle_pct = 83;
    test_random(350);
    test_backpressure();
    send_idle_pct = 83; recv_idle_pct = 27;
    test_random(350);
    drain_results();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(350);

    drain_results();
    repeat (60) @(posedge clk);
    if (errors == 0 && exp_results.size() == 0) begin
      $display("chip8_instruction_execute verification clean");
    end else begin
      $display("chip8_instruction_execute verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/c8ie_pkg.sv
rtl/c8ie_alu.sv
rtl/c8ie_mem.sv
rtl/c8ie_vid.sv
rtl/chip8_instruction_execute.sv
tb/chip8_instruction_execute_tb.sv
